// ===== src/kpcf_pkg.sv =====
// ============================================================================
// kpcf_pkg
// Shared types and constants of the keypad press command framer.
// ============================================================================
package kpcf_pkg;

    localparam int unsigned KEY_W   = 3;
    localparam int unsigned ROCK_W  = 2;
    localparam int unsigned HOLD_W  = 5;
    localparam int unsigned GEAR_W  = 3;
    localparam int unsigned CMD_W   = 4;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    localparam logic [KEY_W-1:0]  KEY_NONE     = 3'd0;
    localparam logic [KEY_W-1:0]  KEY_DIR_LAST = 3'd4;

    localparam logic [ROCK_W-1:0] ROCK_NEUTRAL = 2'd0;
    localparam logic [ROCK_W-1:0] ROCK_UP      = 2'd1;
    localparam logic [ROCK_W-1:0] ROCK_DOWN    = 2'd2;

    localparam logic [HOLD_W-1:0] HOLD_SAT     = 5'd31;

    localparam logic [CMD_W-1:0]  CMD_LONG_OFS = 4'd7;
    localparam logic [CMD_W-1:0]  CMD_GEAR_UP  = 4'd8;
    localparam logic [CMD_W-1:0]  CMD_GEAR_DN  = 4'd9;

    localparam logic [BYTE_W-1:0] FRM_SYNC     = 8'h55;
    localparam logic [BYTE_W-1:0] FRM_LEN      = 8'h05;
    localparam logic [BYTE_W-1:0] FRM_TYPE     = 8'h06;
    localparam logic [BYTE_W-1:0] FRM_ARG      = 8'h01;
    localparam logic [BYTE_W-1:0] FRM_PAD      = 8'h00;

    localparam logic [IDX_W-1:0]  IDX_SYNC     = 3'd0;
    localparam logic [IDX_W-1:0]  IDX_LEN      = 3'd1;
    localparam logic [IDX_W-1:0]  IDX_TYPE     = 3'd2;
    localparam logic [IDX_W-1:0]  IDX_CMD      = 3'd3;
    localparam logic [IDX_W-1:0]  IDX_ARG      = 3'd4;
    localparam logic [IDX_W-1:0]  IDX_LAST     = 3'd5;

    localparam logic [1:0] REG_SHORT_LIMIT = 2'd0;
    localparam logic [1:0] REG_LONG_LIMIT  = 2'd1;
    localparam logic [1:0] REG_GEAR_MIN    = 2'd2;
    localparam logic [1:0] REG_GEAR_MAX    = 2'd3;

    localparam logic [HOLD_W-1:0] SHORT_LIMIT_RST = 5'd10;
    localparam logic [HOLD_W-1:0] LONG_LIMIT_RST  = 5'd20;
    localparam logic [GEAR_W-1:0] GEAR_MIN_RST    = 3'd1;
    localparam logic [GEAR_W-1:0] GEAR_MAX_RST    = 3'd7;
    localparam logic [GEAR_W-1:0] GEAR_RST        = 3'd5;

    typedef struct packed {
        logic [HOLD_W-1:0] short_limit;
        logic [HOLD_W-1:0] long_limit;
        logic [GEAR_W-1:0] gear_min;
        logic [GEAR_W-1:0] gear_max;
    } cfg_t;

    // one accepted tick that produces one or two frames
    typedef struct packed {
        logic              two;
        logic [CMD_W-1:0]  cmd_a;
        logic [CMD_W-1:0]  cmd_b;
        logic [GEAR_W-1:0] gear;
    } job_t;

endpackage

// ===== src/kpcf_cfg_regs.sv =====
// ============================================================================
// kpcf_cfg_regs
// APB-style register file for hold limits and gear limits.
// ============================================================================
module kpcf_cfg_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kpcf_pkg::ADDR_W-1:0]  paddr,
    input  logic [kpcf_pkg::DATA_W-1:0]  pwdata,
    output logic [kpcf_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output kpcf_pkg::cfg_t               cfg
);

    kpcf_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic           aligned;
    logic [1:0]     reg_sel;

    assign pready  = 1'b1;
    assign aligned = (paddr[1:0] == 2'd0);
    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_limit <= kpcf_pkg::SHORT_LIMIT_RST;
            cfg_reg.long_limit  <= kpcf_pkg::LONG_LIMIT_RST;
            cfg_reg.gear_min    <= kpcf_pkg::GEAR_MIN_RST;
            cfg_reg.gear_max    <= kpcf_pkg::GEAR_MAX_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                kpcf_pkg::REG_SHORT_LIMIT: cfg_reg.short_limit <= pwdata[kpcf_pkg::HOLD_W-1:0];
                kpcf_pkg::REG_LONG_LIMIT:  cfg_reg.long_limit  <= pwdata[kpcf_pkg::HOLD_W-1:0];
                kpcf_pkg::REG_GEAR_MIN:    cfg_reg.gear_min    <= pwdata[kpcf_pkg::GEAR_W-1:0];
                kpcf_pkg::REG_GEAR_MAX:    cfg_reg.gear_max    <= pwdata[kpcf_pkg::GEAR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        if (aligned)
        begin
            unique case (reg_sel)
                kpcf_pkg::REG_SHORT_LIMIT: prdata[kpcf_pkg::HOLD_W-1:0] = cfg_reg.short_limit;
                kpcf_pkg::REG_LONG_LIMIT:  prdata[kpcf_pkg::HOLD_W-1:0] = cfg_reg.long_limit;
                kpcf_pkg::REG_GEAR_MIN:    prdata[kpcf_pkg::GEAR_W-1:0] = cfg_reg.gear_min;
                kpcf_pkg::REG_GEAR_MAX:    prdata[kpcf_pkg::GEAR_W-1:0] = cfg_reg.gear_max;
                default: ;
            endcase
        end
    end

endmodule

// ===== src/kpcf_press_logic.sv =====
// ============================================================================
// kpcf_press_logic
// Input register plus key hold / rocker state update; emits at most one job per tick.
// ============================================================================
module kpcf_press_logic
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [kpcf_pkg::KEY_W-1:0]   key_code,
    input  logic [kpcf_pkg::ROCK_W-1:0]  rocker,
    input  kpcf_pkg::cfg_t               cfg,
    output logic                         job_valid,
    input  logic                         job_ready,
    output kpcf_pkg::job_t               job
);

    logic                         in_valid_reg;
    logic [kpcf_pkg::KEY_W-1:0]   key_reg;
    logic [kpcf_pkg::ROCK_W-1:0]  rock_reg;

    logic [kpcf_pkg::HOLD_W-1:0]  hold_count_reg, hold_count_next;
    logic                         long_sent_reg, long_sent_next;
    logic [kpcf_pkg::KEY_W-1:0]   pending_key_reg, pending_key_next;
    logic [kpcf_pkg::GEAR_W-1:0]  speed_gear_reg, speed_gear_next;
    logic                         rocker_armed_reg, rocker_armed_next;

    logic [kpcf_pkg::HOLD_W-1:0]  hold_inc;
    logic [kpcf_pkg::GEAR_W:0]    gear_up;
    logic [kpcf_pkg::GEAR_W-1:0]  gear_dn;
    logic                         key_emit;
    logic                         rock_emit;
    logic [kpcf_pkg::CMD_W-1:0]   key_cmd;
    logic [kpcf_pkg::CMD_W-1:0]   rock_cmd;
    logic                         has_frame;
    logic                         commit;

    always_comb
    begin
        hold_count_next   = hold_count_reg;
        long_sent_next    = long_sent_reg;
        pending_key_next  = pending_key_reg;
        speed_gear_next   = speed_gear_reg;
        rocker_armed_next = rocker_armed_reg;
        key_emit          = 1'b0;
        rock_emit         = 1'b0;
        key_cmd           = '0;
        rock_cmd          = '0;
        hold_inc = (hold_count_reg < kpcf_pkg::HOLD_SAT) ?
                   hold_count_reg + kpcf_pkg::HOLD_W'(1) : hold_count_reg;
        gear_up  = {1'b0, speed_gear_reg} + (kpcf_pkg::GEAR_W+1)'(1);
        gear_dn  = speed_gear_reg - kpcf_pkg::GEAR_W'(1);

        if (key_reg != kpcf_pkg::KEY_NONE)
        begin
            if (key_reg <= kpcf_pkg::KEY_DIR_LAST)
            begin
                pending_key_next = key_reg;
            end
            else
            begin
                hold_count_next = hold_inc;
                if (hold_inc < cfg.short_limit)
                begin
                    pending_key_next = key_reg;
                end
                else if (hold_inc > cfg.long_limit)
                begin
                    hold_count_next = cfg.long_limit + kpcf_pkg::HOLD_W'(1);
                    if (!long_sent_reg)
                    begin
                        key_emit = 1'b1;
                        key_cmd  = {1'b0, key_reg} + kpcf_pkg::CMD_LONG_OFS;
                    end
                    long_sent_next = 1'b1;
                end
                else
                begin
                    pending_key_next = kpcf_pkg::KEY_NONE;
                end
            end
        end
        else
        begin
            hold_count_next = '0;
            long_sent_next  = 1'b0;
            if (pending_key_reg != kpcf_pkg::KEY_NONE)
            begin
                key_emit = 1'b1;
                key_cmd  = {1'b0, pending_key_reg};
            end
            pending_key_next = kpcf_pkg::KEY_NONE;
        end

        case (rock_reg)
            kpcf_pkg::ROCK_UP:
            begin
                if (rocker_armed_reg)
                begin
                    speed_gear_next   = (gear_up > {1'b0, cfg.gear_max}) ?
                                        cfg.gear_max : gear_up[kpcf_pkg::GEAR_W-1:0];
                    rock_emit         = 1'b1;
                    rock_cmd          = kpcf_pkg::CMD_GEAR_UP;
                    rocker_armed_next = 1'b0;
                end
            end
            kpcf_pkg::ROCK_DOWN:
            begin
                if (rocker_armed_reg)
                begin
                    // gear zero would go negative: clamp to minimum
                    speed_gear_next   = (speed_gear_reg == '0 || gear_dn < cfg.gear_min) ?
                                        cfg.gear_min : gear_dn;
                    rock_emit         = 1'b1;
                    rock_cmd          = kpcf_pkg::CMD_GEAR_DN;
                    rocker_armed_next = 1'b0;
                end
            end
            kpcf_pkg::ROCK_NEUTRAL:
            begin
                rocker_armed_next = 1'b1;
            end
            default: ;
        endcase
    end

    assign has_frame = key_emit || rock_emit;
    assign commit    = in_valid_reg && (!has_frame || job_ready);
    assign in_ready  = !in_valid_reg || commit;
    assign job_valid = in_valid_reg && has_frame;

    assign job.two   = key_emit && rock_emit;
    assign job.cmd_a = key_emit ? key_cmd : rock_cmd;
    assign job.cmd_b = rock_cmd;
    assign job.gear  = speed_gear_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            hold_count_reg   <= '0;
            long_sent_reg    <= 1'b0;
            pending_key_reg  <= kpcf_pkg::KEY_NONE;
            speed_gear_reg   <= kpcf_pkg::GEAR_RST;
            rocker_armed_reg <= 1'b1;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (commit)
            begin
                hold_count_reg   <= hold_count_next;
                long_sent_reg    <= long_sent_next;
                pending_key_reg  <= pending_key_next;
                speed_gear_reg   <= speed_gear_next;
                rocker_armed_reg <= rocker_armed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            key_reg  <= key_code;
            rock_reg <= rocker;
        end
    end

endmodule

// ===== src/kpcf_frame_ser.sv =====
// ============================================================================
// kpcf_frame_ser
// Job register and byte sequencer: sends one or two six-byte frames per job.
// ============================================================================
module kpcf_frame_ser
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         job_valid,
    output logic                         job_ready,
    input  kpcf_pkg::job_t               job,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [kpcf_pkg::BYTE_W-1:0]  frame_byte,
    output logic [kpcf_pkg::IDX_W-1:0]   byte_index,
    output logic                         last_byte,
    output logic [kpcf_pkg::GEAR_W-1:0]  gear
);

    kpcf_pkg::job_t               job_reg;
    logic                         busy_reg;
    logic                         sel_reg;
    logic [kpcf_pkg::IDX_W-1:0]   idx_reg;
    logic [kpcf_pkg::CMD_W-1:0]   cur_cmd;
    logic                         frame_end;
    logic                         done;
    logic                         load;

    assign cur_cmd   = sel_reg ? job_reg.cmd_b : job_reg.cmd_a;
    assign frame_end = (idx_reg == kpcf_pkg::IDX_LAST);
    assign last_byte = frame_end && (sel_reg || !job_reg.two);
    assign done      = busy_reg && out_ready && last_byte;
    assign job_ready = !busy_reg || done;
    assign load      = job_valid && job_ready;

    assign out_valid  = busy_reg;
    assign byte_index = idx_reg;
    assign gear       = job_reg.gear;

    always_comb
    begin
        case (idx_reg)
            kpcf_pkg::IDX_SYNC: frame_byte = kpcf_pkg::FRM_SYNC;
            kpcf_pkg::IDX_LEN:  frame_byte = kpcf_pkg::FRM_LEN;
            kpcf_pkg::IDX_TYPE: frame_byte = kpcf_pkg::FRM_TYPE;
            kpcf_pkg::IDX_CMD:  frame_byte = {{(kpcf_pkg::BYTE_W-kpcf_pkg::CMD_W){1'b0}}, cur_cmd};
            kpcf_pkg::IDX_ARG:  frame_byte = kpcf_pkg::FRM_ARG;
            default:            frame_byte = kpcf_pkg::FRM_PAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sel_reg  <= 1'b0;
            idx_reg  <= kpcf_pkg::IDX_SYNC;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            sel_reg  <= 1'b0;
            idx_reg  <= kpcf_pkg::IDX_SYNC;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg && out_ready)
        begin
            if (frame_end)
            begin
                sel_reg <= 1'b1;
                idx_reg <= kpcf_pkg::IDX_SYNC;
            end
            else
            begin
                idx_reg <= idx_reg + kpcf_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= job;
        end
    end

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> idx_reg <= kpcf_pkg::IDX_LAST)
        else $error("byte index out of frame");

    a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> busy_reg && idx_reg == kpcf_pkg::IDX_SYNC && !sel_reg)
        else $error("job load did not restart sequencer");

    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && out_ready && !frame_end |=> idx_reg == $past(idx_reg) + kpcf_pkg::IDX_W'(1))
        else $error("byte index skipped");

    a_second_frame: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && sel_reg |-> job_reg.two)
        else $error("second frame without two-frame job");

    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done && !job_valid |=> !busy_reg)
        else $error("sequencer stayed busy after last byte");

endmodule

// ===== src/keypad_press_command_framer_core.sv =====
// ============================================================================
// keypad_press_command_framer_core
// Keypad / joystick poll ticks in, six-byte command frames out.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready, key_code, rocker): one request per poll
//   tick. Output channel (out_valid/out_ready): one frame byte per request,
//   zero, six or twelve bytes per tick; last_byte marks the final byte of a
//   tick and gear carries the speed gear after that tick.
//   Configuration registers (APB, 4-byte stride): short_limit, long_limit,
//   gear_min, gear_max; write only while idle.
//   Path: a tick is held in the input register, then its job is loaded into
//   the job register, which drives the bytes. Bytes leave one per cycle
//   while out_ready is high. A tick producing no frame does not wait for
//   the output sequencer; otherwise the next tick is taken while the
//   current job drains its last byte.
//   Reset: gear 5, rocker armed, no key pending, limits 10/20/1/7.
//   A stalled receiver holds the current byte; at most one further tick
//   waits in the input register, and in_ready drops behind it.
// ============================================================================
module keypad_press_command_framer_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kpcf_pkg::ADDR_W-1:0]  paddr,
    input  logic [kpcf_pkg::DATA_W-1:0]  pwdata,
    output logic [kpcf_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [kpcf_pkg::KEY_W-1:0]   key_code,
    input  logic [kpcf_pkg::ROCK_W-1:0]  rocker,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [kpcf_pkg::BYTE_W-1:0]  frame_byte,
    output logic [kpcf_pkg::IDX_W-1:0]   byte_index,
    output logic                         last_byte,
    output logic [kpcf_pkg::GEAR_W-1:0]  gear
);

    kpcf_pkg::cfg_t cfg;
    kpcf_pkg::job_t job;
    logic           job_valid;
    logic           job_ready;

    kpcf_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kpcf_press_logic u_press
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .key_code  (key_code),
        .rocker    (rocker),
        .cfg       (cfg),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    kpcf_frame_ser u_ser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_byte (frame_byte),
        .byte_index (byte_index),
        .last_byte  (last_byte),
        .gear       (gear)
    );

endmodule
